>>> src/ffea_pkg.sv
package ffea_pkg;

    localparam int MAX_EXT = 64;
    localparam int IDX_W   = $clog2(MAX_EXT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = ADDR_W + 1;
    localparam int WAIT_W  = 16;

    localparam logic [SIZE_W-1:0] POOL_MAX   = SIZE_W'(1) << ADDR_W;
    localparam logic [SIZE_W-1:0] WAKE_RST   = SIZE_W'(50000);
    localparam logic [WAIT_W-1:0] WAIT_MAX   = '1;
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_EXT);

    // response status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_OVERLAP  = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // configuration register indexes
    localparam logic CFG_POOL_SIZE = 1'b0;
    localparam logic CFG_WAKE_THR  = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHDN,
        S_SHUP,
        S_INS,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] len;
    } t_ext;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_ext             wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

>>> src/ffea_table.sv
module ffea_table (
    input  logic              i_clk,
    input  ffea_pkg::t_mem_req i_req,
    output ffea_pkg::t_ext    o_rdata
);
    import ffea_pkg::*;

    t_ext r_mem [MAX_EXT];
    t_ext r_rdata;

    // extent table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ffea_ctrl.sv
module ffea_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [ffea_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic                          i_mode,
    input  logic [ffea_pkg::ADDR_W-1:0]   i_block_addr,
    input  logic [ffea_pkg::SIZE_W-1:0]   i_block_size,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic [ffea_pkg::ADDR_W-1:0]   o_alloc_addr,
    output logic [1:0]                    o_status,
    output logic                          o_wake,
    output logic [ffea_pkg::SIZE_W-1:0]   o_free_total,
    output ffea_pkg::t_mem_req            o_mem,
    input  ffea_pkg::t_ext                i_rdata
);
    import ffea_pkg::*;

    t_state r_state, n_state;
    logic              r_mode, n_mode;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W:0]   r_end, n_end;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_ins, n_ins;
    logic [SIZE_W-1:0] r_ft, n_ft;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [SIZE_W-1:0] r_pool, n_pool;
    logic [SIZE_W-1:0] r_thr, n_thr;
    logic [ADDR_W-1:0] r_prev_start, n_prev_start;
    logic [SIZE_W:0]   r_prev_end, n_prev_end;
    logic              r_has_prev, n_has_prev;
    logic [1:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_got, n_got;
    logic              r_o_valid, n_o_valid;
    logic [ADDR_W-1:0] r_o_addr, n_o_addr;
    logic [1:0]        r_o_status, n_o_status;
    logic              r_o_wake, n_o_wake;
    logic [SIZE_W-1:0] r_o_ft, n_o_ft;

    logic              in_range, more, ovl, j_prev, j_next, wake;
    logic [SIZE_W:0]   nxt_end;
    logic [SIZE_W-1:0] cfg_v;

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= CNT_W'(1);
            r_ft      <= POOL_MAX;
            r_wait    <= '0;
            r_pool    <= POOL_MAX;
            r_thr     <= WAKE_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ft      <= n_ft;
            r_wait    <= n_wait;
            r_pool    <= n_pool;
            r_thr     <= n_thr;
            r_o_valid <= n_o_valid;
        end
        r_mode       <= n_mode;
        r_addr       <= n_addr;
        r_size       <= n_size;
        r_end        <= n_end;
        r_ptr        <= n_ptr;
        r_ins        <= n_ins;
        r_prev_start <= n_prev_start;
        r_prev_end   <= n_prev_end;
        r_has_prev   <= n_has_prev;
        r_status     <= n_status;
        r_got        <= n_got;
        r_o_addr     <= n_o_addr;
        r_o_status   <= n_o_status;
        r_o_wake     <= n_o_wake;
        r_o_ft       <= n_o_ft;
    end

    // sequencer: take config writes and requests, scan, shift and fix up the extent table, load the response
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_addr       = r_addr;
        n_size       = r_size;
        n_end        = r_end;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_ins        = r_ins;
        n_ft         = r_ft;
        n_wait       = r_wait;
        n_pool       = r_pool;
        n_thr        = r_thr;
        n_prev_start = r_prev_start;
        n_prev_end   = r_prev_end;
        n_has_prev   = r_has_prev;
        n_status     = r_status;
        n_got        = r_got;
        n_o_valid    = r_o_valid;
        n_o_addr     = r_o_addr;
        n_o_status   = r_o_status;
        n_o_wake     = r_o_wake;
        n_o_ft       = r_o_ft;
        o_mem.we     = 1'b0;
        o_mem.waddr  = r_ptr[IDX_W-1:0];
        o_mem.wdata  = i_rdata;
        o_mem.raddr  = r_ptr[IDX_W-1:0];
        o_cfg_ready  = 1'b0;
        o_req_ready  = 1'b0;

        in_range = r_ptr < r_cnt;
        more     = (r_ptr + CNT_W'(1)) < r_cnt;
        nxt_end  = {1'b0, i_rdata.len} + (SIZE_W+1)'(i_rdata.start);
        ovl      = (r_has_prev && r_prev_end > (SIZE_W+1)'(r_addr))
                   || (in_range && r_end > (SIZE_W+1)'(i_rdata.start));
        j_prev   = r_has_prev && r_prev_end == (SIZE_W+1)'(r_addr);
        j_next   = in_range && r_end == (SIZE_W+1)'(i_rdata.start);
        wake     = (r_mode == MODE_FREE) && (r_status == STAT_OK)
                   && (r_wait != '0) && (r_ft > r_thr);

        cfg_v = i_cfg_data;
        if (cfg_v == '0) begin
            cfg_v = SIZE_W'(1);
        end else if (cfg_v > POOL_MAX) begin
            cfg_v = POOL_MAX;
        end

        // response register drains independently
        if (r_o_valid && i_rsp_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_req_ready = !i_cfg_valid;
                o_mem.raddr = '0;
                if (i_cfg_valid) begin
                    if (i_cfg_index == CFG_POOL_SIZE) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = '0;
                        o_mem.wdata = '{start: '0, len: cfg_v};
                        n_pool      = cfg_v;
                        n_cnt       = CNT_W'(1);
                        n_ft        = cfg_v;
                    end else if (i_cfg_index == CFG_WAKE_THR) begin
                        n_thr = i_cfg_data;
                    end
                end else if (i_req_valid) begin
                    n_mode     = i_mode;
                    n_addr     = i_block_addr;
                    n_size     = i_block_size;
                    n_end      = (SIZE_W+1)'(i_block_addr) + (SIZE_W+1)'(i_block_size);
                    n_ptr      = '0;
                    n_has_prev = 1'b0;
                    n_got      = '0;
                    n_status   = STAT_OK;
                    n_state    = S_SCAN;
                    if (i_block_size == '0) begin
                        n_status = (i_mode == MODE_ALLOC) ? STAT_NO_SPACE : STAT_OVERLAP;
                        n_state  = S_FIN;
                    end else if (i_mode == MODE_FREE
                                 && ((SIZE_W+1)'(i_block_addr) + (SIZE_W+1)'(i_block_size))
                                    > (SIZE_W+1)'(r_pool)) begin
                        n_status = STAT_OVERLAP;
                        n_state  = S_FIN;
                    end
                end
            end

            S_SCAN: begin
                if (r_mode == MODE_ALLOC) begin
                    // first extent large enough
                    if (in_range && i_rdata.len >= r_size) begin
                        n_got = i_rdata.start;
                        n_ft  = r_ft - r_size;
                        if (i_rdata.len > r_size) begin
                            o_mem.we    = 1'b1;
                            o_mem.wdata = '{start: i_rdata.start + r_size[ADDR_W-1:0],
                                            len: i_rdata.len - r_size};
                            n_state     = S_FIN;
                        end else if (more) begin
                            n_ptr       = r_ptr + CNT_W'(1);
                            o_mem.raddr = n_ptr[IDX_W-1:0];
                            n_state     = S_SHDN;
                        end else begin
                            n_cnt   = r_cnt - CNT_W'(1);
                            n_state = S_FIN;
                        end
                    end else if (in_range) begin
                        n_ptr       = r_ptr + CNT_W'(1);
                        o_mem.raddr = n_ptr[IDX_W-1:0];
                    end else begin
                        n_status = STAT_NO_SPACE;
                        if (r_wait != WAIT_MAX) begin
                            n_wait = r_wait + WAIT_W'(1);
                        end
                        n_state = S_FIN;
                    end
                end else begin
                    // walk past extents below the freed block
                    if (in_range && i_rdata.start < r_addr) begin
                        n_prev_start = i_rdata.start;
                        n_prev_end   = nxt_end;
                        n_has_prev   = 1'b1;
                        n_ptr        = r_ptr + CNT_W'(1);
                        o_mem.raddr  = n_ptr[IDX_W-1:0];
                    end else if (ovl) begin
                        n_status = STAT_OVERLAP;
                        n_state  = S_FIN;
                    end else if (j_prev) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = IDX_W'(r_ptr - CNT_W'(1));
                        o_mem.wdata.start = r_prev_start;
                        o_mem.wdata.len   = j_next
                            ? SIZE_W'(nxt_end - (SIZE_W+1)'(r_prev_start))
                            : SIZE_W'(r_end - (SIZE_W+1)'(r_prev_start));
                        n_ft    = r_ft + r_size;
                        n_state = S_FIN;
                        if (j_next) begin
                            if (more) begin
                                n_ptr       = r_ptr + CNT_W'(1);
                                o_mem.raddr = n_ptr[IDX_W-1:0];
                                n_state     = S_SHDN;
                            end else begin
                                n_cnt = r_cnt - CNT_W'(1);
                            end
                        end
                    end else if (j_next) begin
                        o_mem.we    = 1'b1;
                        o_mem.wdata = '{start: r_addr, len: i_rdata.len + r_size};
                        n_ft        = r_ft + r_size;
                        n_state     = S_FIN;
                    end else if (r_cnt >= CNT_FULL) begin
                        n_status = STAT_FULL;
                        n_state  = S_FIN;
                    end else if (!in_range) begin
                        o_mem.we    = 1'b1;
                        o_mem.wdata = '{start: r_addr, len: r_size};
                        n_cnt       = r_cnt + CNT_W'(1);
                        n_ft        = r_ft + r_size;
                        n_state     = S_FIN;
                    end else begin
                        n_ins       = r_ptr[IDX_W-1:0];
                        n_ptr       = r_cnt - CNT_W'(1);
                        o_mem.raddr = n_ptr[IDX_W-1:0];
                        n_ft        = r_ft + r_size;
                        n_state     = S_SHUP;
                    end
                end
            end

            // close the gap: move each entry one slot down
            S_SHDN: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = IDX_W'(r_ptr - CNT_W'(1));
                if (more) begin
                    n_ptr       = r_ptr + CNT_W'(1);
                    o_mem.raddr = n_ptr[IDX_W-1:0];
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_FIN;
                end
            end

            // open a slot: move each entry one slot up, top first
            S_SHUP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = IDX_W'(r_ptr + CNT_W'(1));
                if (r_ptr > CNT_W'(r_ins)) begin
                    n_ptr       = r_ptr - CNT_W'(1);
                    o_mem.raddr = n_ptr[IDX_W-1:0];
                end else begin
                    n_state = S_INS;
                end
            end

            S_INS: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ins;
                o_mem.wdata = '{start: r_addr, len: r_size};
                n_cnt       = r_cnt + CNT_W'(1);
                n_state     = S_FIN;
            end

            // load response once the output register is free
            S_FIN: begin
                if (!r_o_valid || i_rsp_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_addr   = r_got;
                    n_o_status = r_status;
                    n_o_wake   = wake;
                    n_o_ft     = r_ft;
                    if (wake) begin
                        n_wait = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid  = r_o_valid;
    assign o_alloc_addr = r_o_addr;
    assign o_status     = r_o_status;
    assign o_wake       = r_o_wake;
    assign o_free_total = r_o_ft;

endmodule

>>> src/first_fit_extent_allocator.sv
// First-fit extent allocator.
// Request channel (i_req_valid / o_req_ready) carries i_mode (0 allocate,
// 1 free), i_block_addr and i_block_size. One response per request on
// o_rsp_valid / i_rsp_ready with o_alloc_addr, o_status, o_wake and
// o_free_total. Configuration writes (i_cfg_valid / o_cfg_ready) are taken
// only between requests; index 0 sets the pool size and rebuilds the table
// as one extent, index 1 sets the wake threshold.
// Structure: the table lives in one RAM with one read and one write port and
// a registered read. A request scans entries at one per cycle, then shifts
// entries one per cycle when an extent is removed or inserted. The scan
// stops where the shift begins, so the entries scanned and moved together
// stay near the extent count. One request is in flight at a time.
// Reset (synchronous, active low) gives a pool of 2^20 as one extent, a
// wake threshold of 50000 and no waiters. A finished response waits in the
// output register while the next request is taken; if the receiver stalls
// with the register still full, the next request holds before its response.
module first_fit_extent_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [ffea_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic                        i_mode,
    input  logic [ffea_pkg::ADDR_W-1:0] i_block_addr,
    input  logic [ffea_pkg::SIZE_W-1:0] i_block_size,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic [ffea_pkg::ADDR_W-1:0] o_alloc_addr,
    output logic [1:0]                  o_status,
    output logic                        o_wake,
    output logic [ffea_pkg::SIZE_W-1:0] o_free_total
);
    import ffea_pkg::*;

    t_mem_req mem_req;
    t_mem_req mem_req_rst;
    t_ext     rdata;

    // reset loads the whole pool into entry 0
    always_comb begin
        mem_req_rst = mem_req;
        if (!i_rst_n) begin
            mem_req_rst.we    = 1'b1;
            mem_req_rst.waddr = '0;
            mem_req_rst.wdata = '{start: '0, len: POOL_MAX};
        end
    end

    ffea_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_mode       (i_mode),
        .i_block_addr (i_block_addr),
        .i_block_size (i_block_size),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_alloc_addr (o_alloc_addr),
        .o_status     (o_status),
        .o_wake       (o_wake),
        .o_free_total (o_free_total),
        .o_mem        (mem_req),
        .i_rdata      (rdata)
    );

    ffea_table u_table (
        .i_clk   (i_clk),
        .i_req   (mem_req_rst),
        .o_rdata (rdata)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ffea_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_request;

    typedef struct {
        logic [ADDR_W-1:0] alloc_addr;
        logic [1:0]        status;
        logic              wake;
        logic [SIZE_W-1:0] free_total;
    } t_answer;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_block;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              i_req_valid;
    logic              o_req_ready;
    logic              i_mode;
    logic [ADDR_W-1:0] i_block_addr;
    logic [SIZE_W-1:0] i_block_size;
    logic              o_rsp_valid;
    logic              i_rsp_ready;
    logic [ADDR_W-1:0] o_alloc_addr;
    logic [1:0]        o_status;
    logic              o_wake;
    logic [SIZE_W-1:0] o_free_total;

    first_fit_extent_allocator u_dut (.*);

    // shadow free-extent table
    longint ext_start [MAX_EXT];
    longint ext_len [MAX_EXT];
    int     ext_cnt;
    longint free_sum;
    longint pool_sz;
    longint wake_thr;
    int     waiters;

    t_request pending_q[$];
    t_answer  answer_q[$];
    t_block   live_q[$];

    int  send_idle_pct;
    int  rsp_stall_pct;
    int  size_cap;
    bit  hold_req;
    int  hold_left;
    bit  req_taken;
    int  cycles;
    int  fail_cnt;
    int  n_req;
    int  n_stat [4];
    int  n_wake;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic void table_rebuild();
        for (int k = 0; k < MAX_EXT; k++) begin
            ext_start[k] = 0;
            ext_len[k] = 0;
        end
        ext_len[0] = pool_sz;
        ext_cnt = 1;
        free_sum = pool_sz;
    endfunction

    function automatic void extent_remove(int pos);
        for (int k = pos; k + 1 < ext_cnt; k++) begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_cnt--;
        ext_start[ext_cnt] = 0;
        ext_len[ext_cnt] = 0;
    endfunction

    function automatic void cfg_apply(logic idx, logic [SIZE_W-1:0] data);
        longint v;
        v = data;
        if (idx == CFG_POOL_SIZE) begin
            if (v == 0) v = 1;
            if (v > POOL_MAX) v = POOL_MAX;
            pool_sz = v;
            table_rebuild();
        end else begin
            wake_thr = v;
        end
    endfunction

    // first fit allocation: trim low end or drop exact match
    function automatic logic [1:0] carve_block(longint size, output longint got);
        got = 0;
        if (size == 0) return STAT_NO_SPACE;
        for (int k = 0; k < ext_cnt; k++) begin
            if (ext_len[k] >= size) begin
                got = ext_start[k];
                if (ext_len[k] > size) begin
                    ext_start[k] += size;
                    ext_len[k] -= size;
                end else begin
                    extent_remove(k);
                end
                free_sum -= size;
                return STAT_OK;
            end
        end
        if (waiters < WAIT_MAX) waiters++;
        return STAT_NO_SPACE;
    endfunction

    // return a block to the table, merging with touching neighbors
    function automatic logic [1:0] return_block(longint a, longint s);
        longint e;
        longint pend;
        int     k;
        bit     jp;
        bit     jn;
        e = a + s;
        k = 0;
        jp = 0;
        jn = 0;
        if (s == 0 || e > pool_sz) return STAT_OVERLAP;
        while (k < ext_cnt && ext_start[k] < a) k++;
        if (k > 0) begin
            pend = ext_start[k - 1] + ext_len[k - 1];
            if (pend > a) return STAT_OVERLAP;
            jp = (pend == a);
        end
        if (k < ext_cnt) begin
            if (e > ext_start[k]) return STAT_OVERLAP;
            jn = (e == ext_start[k]);
        end
        if (jp && jn) begin
            ext_len[k - 1] += s + ext_len[k];
            extent_remove(k);
        end else if (jp) begin
            ext_len[k - 1] += s;
        end else if (jn) begin
            ext_start[k] = a;
            ext_len[k] += s;
        end else begin
            if (ext_cnt >= MAX_EXT) return STAT_FULL;
            for (int m = ext_cnt; m > k; m--) begin
                ext_start[m] = ext_start[m - 1];
                ext_len[m] = ext_len[m - 1];
            end
            ext_start[k] = a;
            ext_len[k] = s;
            ext_cnt++;
        end
        free_sum += s;
        return STAT_OK;
    endfunction

    function automatic t_answer predict_answer(t_request rq);
        t_answer ans;
        longint  got;
        got = 0;
        ans.wake = 1'b0;
        if (rq.mode == MODE_ALLOC) begin
            ans.status = carve_block(rq.size, got);
            if (ans.status == STAT_OK) live_q.push_back('{ADDR_W'(got), rq.size});
        end else begin
            ans.status = return_block(rq.addr, rq.size);
            if (ans.status == STAT_OK && waiters > 0 && free_sum > wake_thr) begin
                ans.wake = 1'b1;
                waiters = 0;
            end
        end
        ans.alloc_addr = ADDR_W'(got);
        ans.free_total = SIZE_W'(free_sum);
        return ans;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || req_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_req_valid <= 1'b1;
                i_mode <= pending_q[0].mode;
                i_block_addr <= pending_q[0].addr;
                i_block_size <= pending_q[0].size;
                void'(pending_q.pop_front());
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // response stall, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 600;
            hold_req <= 1'b0;
            i_rsp_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // accept tracking and response checking
    always @(posedge i_clk) begin
        t_request rq;
        t_answer  want;
        cycles <= cycles + 1;
        req_taken <= i_req_valid && o_req_ready;
        if (i_req_valid && o_req_ready) begin
            rq = '{i_mode, i_block_addr, i_block_size};
            answer_q.push_back(predict_answer(rq));
            n_req++;
        end
        if (o_rsp_valid && i_rsp_ready) begin
            if (answer_q.size() == 0) begin
                $error("response with no request outstanding");
                fail_cnt++;
            end else begin
                want = answer_q.pop_front();
                n_stat[o_status]++;
                if (o_wake) n_wake++;
                if (o_alloc_addr !== want.alloc_addr) begin
                    $error("alloc_addr: expected %0d got %0d", want.alloc_addr, o_alloc_addr);
                    fail_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, o_status);
                    fail_cnt++;
                end
                if (o_wake !== want.wake) begin
                    $error("wake: expected %0d got %0d", want.wake, o_wake);
                    fail_cnt++;
                end
                if (o_free_total !== want.free_total) begin
                    $error("free_total: expected %0d got %0d", want.free_total, o_free_total);
                    fail_cnt++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic queue_request(logic m, longint a, longint s);
        while (pending_q.size() >= 4) @(posedge i_clk);
        pending_q.push_back('{m, ADDR_W'(a), SIZE_W'(s)});
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_req_valid || answer_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, longint data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= SIZE_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_apply(idx, SIZE_W'(data));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly allocs and frees of live blocks, some noise
    task automatic random_requests(int count, int hold_at);
        int     pick;
        int     r;
        t_block b;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            r = $urandom_range(99);
            if (r < 8) begin
                queue_request($urandom_range(1), $urandom, $urandom & 21'h1fffff);
            end else if (r < 55 && live_q.size() > 0) begin
                pick = $urandom_range(live_q.size() - 1);
                b = live_q[pick];
                live_q.delete(pick);
                queue_request(MODE_FREE, b.addr, b.size);
            end else if (r < 58) begin
                queue_request(MODE_ALLOC, $urandom, $urandom_range(1, 4 * size_cap));
            end else begin
                queue_request(MODE_ALLOC, $urandom, $urandom_range(1, size_cap));
            end
        end
    endtask

    task automatic run_phase(longint pool, longint thr, int idle, int stall, int cap, int count,
                             int hold_at);
        drain();
        live_q.delete();
        write_reg(CFG_POOL_SIZE, pool);
        write_reg(CFG_WAKE_THR, thr);
        send_idle_pct = idle;
        rsp_stall_pct = stall;
        size_cap = cap;
        random_requests(count, hold_at);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_POOL_SIZE;
        i_cfg_data = '0;
        i_req_valid = 1'b0;
        i_mode = MODE_ALLOC;
        i_block_addr = '0;
        i_block_size = '0;
        i_rsp_ready = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        req_taken = 1'b0;
        cycles = 0;
        fail_cnt = 0;
        n_req = 0;
        n_wake = 0;
        n_stat = '{0, 0, 0, 0};
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        pool_sz = POOL_MAX;
        wake_thr = WAKE_RST;
        waiters = 0;
        table_rebuild();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edge sizes, the ok, no-space and overlap statuses, merges into the next extent and into both
        queue_request(MODE_ALLOC, 0, 0);
        queue_request(MODE_ALLOC, 20'hfffff, 21'h1fffff);
        queue_request(MODE_ALLOC, 0, 1);
        queue_request(MODE_ALLOC, 0, 1048575);
        queue_request(MODE_ALLOC, 0, 1);
        queue_request(MODE_FREE, 0, 0);
        queue_request(MODE_FREE, 20'hfffff, 2);
        queue_request(MODE_FREE, 20'hfffff, 1);
        queue_request(MODE_FREE, 0, 1);
        queue_request(MODE_FREE, 0, 1);
        queue_request(MODE_FREE, 1, 1048574);
        queue_request(MODE_ALLOC, 0, 10);
        queue_request(MODE_ALLOC, 0, 10);
        queue_request(MODE_ALLOC, 0, 10);
        queue_request(MODE_FREE, 10, 10);
        queue_request(MODE_FREE, 0, 10);
        queue_request(MODE_FREE, 20, 10);
        queue_request(MODE_FREE, 5, 30);
        queue_request(MODE_ALLOC, 0, 1048576);
        queue_request(MODE_FREE, 0, 1048576);

        run_phase(1048576, 50000, 0, 0, 65536, 200, -1);
        run_phase(4096, 1000, 47, 0, 16, 300, -1);
        run_phase(4096, 0, 0, 47, 16, 300, 100);
        run_phase(0, 1048576, 35, 35, 2, 100, -1);
        run_phase(300000, 100000, 35, 35, 20000, 300, -1);
        run_phase(21'h1fffff, 2000, 0, 0, 8, 400, -1);
        drain();

        if (answer_q.size() > 0) begin
            $error("%0d responses never arrived", answer_q.size());
            fail_cnt++;
        end
        $display("covered %0d requests over six pool settings: ok %0d, no_space %0d,",
                 n_req, n_stat[0], n_stat[1]);
        $display("overlap %0d, table_full %0d, wakes %0d", n_stat[2], n_stat[3], n_wake);
        if (fail_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
